[sv/drgc_pkg.sv]
// Shared types and constants for the grid raycaster column unit.
package drgc_pkg;

    localparam int NUM_W  = 33;
    localparam int DEN_W  = 44;
    localparam int DIST_W = 48;
    localparam int RAY_W  = 32;
    localparam int CAM_W  = 29;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;

    localparam logic [20:0] POS_X_RST   = 21'd98304;
    localparam logic [20:0] POS_Y_RST   = 21'd98304;
    localparam logic [18:0] DIR_X_RST   = 19'h70000;
    localparam logic [18:0] DIR_Y_RST   = 19'd0;
    localparam logic [18:0] PLANE_X_RST = 19'd0;
    localparam logic [18:0] PLANE_Y_RST = 19'd43254;

    typedef struct packed {
        logic       operation;
        logic [9:0] column;
        logic [9:0] cell_index;
        logic [7:0] cell_value;
    } cmd_t;

    typedef struct packed {
        logic [9:0]  out_column;
        logic        side_hit;
        logic [4:0]  hit_cell_x;
        logic [4:0]  hit_cell_y;
        logic [31:0] wall_distance;
        logic [15:0] line_height;
        logic [8:0]  draw_start;
        logic [8:0]  draw_end;
        logic [2:0]  texture_index;
        logic [5:0]  texture_column;
        logic        no_hit;
    } result_t;

    typedef struct packed {
        logic             go;
        logic [NUM_W-1:0] numer;
        logic [DEN_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

[sv/drgc_ram.sv]
// Generic single-port-write RAM with registered read.
module drgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/drgc_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module drgc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  drgc_pkg::div_req_t req,
    output drgc_pkg::div_rsp_t rsp
);

    localparam int NW    = drgc_pkg::NUM_W;
    localparam int DW    = drgc_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW);

    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    rem_next;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic             qbit;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        qbit     = trial >= {1'b0, den_reg};
        rem_next = qbit ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NW - 1);
                rem_reg <= '0;
                quo_reg <= req.numer;
                den_reg <= req.denom;
            end
            else if (run_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[NW-2:0], qbit};
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[sv/dda_grid_raycast_column_unit.sv]
// Grid raycaster top level: sequencer, shared multiplier, map RAM and divider.
//
//  channel   signals                              beat taken when
//  command   start, busy, cmd                     start && !busy
//  result    done, result                         done (one cycle, no stall)
//  config    cfg_write, cfg_index, cfg_data       cfg_write
//
// A map write leaves the unit idle. A cast walks the map with a step state and a
// test state per cell. The radix-2 divider gives both ray reciprocals and, on a
// hit at nonzero distance, the line height.
// The camera offset is a reciprocal multiply on the shared multiplier.
// Reset restores the camera registers; map contents stay undefined.
// The result is shown for one cycle with done and cannot be held off.
module dda_grid_raycast_column_unit #(
    parameter int SCREEN_COLUMNS = 640,
    parameter int SCREEN_ROWS    = 480,
    parameter int MAP_SIDE       = 32,
    parameter int TEXTURE_COUNT  = 8,
    parameter int TEXTURE_SIDE   = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  drgc_pkg::cmd_t    cmd,
    output logic              done,
    output drgc_pkg::result_t result,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [20:0]       cfg_data
);

    localparam int CELLS      = MAP_SIDE * MAP_SIDE;
    localparam int AW         = $clog2(CELLS);
    localparam int STEP_LIMIT = 2 * MAP_SIDE;
    localparam int SW         = $clog2(STEP_LIMIT);
    localparam int CW         = ((MAP_SIDE > 32) ? $clog2(MAP_SIDE) : 5) + 2;
    localparam int NW         = drgc_pkg::NUM_W;
    localparam int DW         = drgc_pkg::DEN_W;
    localparam int DIST_W     = drgc_pkg::DIST_W;
    localparam int RAY_W      = drgc_pkg::RAY_W;
    localparam int CAM_W      = drgc_pkg::CAM_W;
    localparam int CAM_SH     = 29 + $clog2(SCREEN_COLUMNS);

    localparam logic signed [CW-1:0] ONE_S  = CW'(1);
    localparam logic signed [CW-1:0] SIDE_S = CW'(MAP_SIDE);
    localparam logic [12:0] COLS_L      = 13'(SCREEN_COLUMNS);
    localparam logic [16:0] ROWS_L      = 17'(SCREEN_ROWS);
    localparam logic [16:0] HALF_ROWS_L = 17'(SCREEN_ROWS / 2);
    localparam logic [16:0] TEX_SIDE_L  = 17'(TEXTURE_SIDE);
    localparam logic [8:0]  TEX_CNT_L   = 9'(TEXTURE_COUNT);
    localparam logic [NW-1:0] LH_NUMER  = NW'(SCREEN_ROWS * 3 * 65536);
    localparam logic [NW-1:0] RECIP_NUM = NW'(64'h1_0000_0000);
    localparam logic [32:0] CAM_MUL     = 33'(((64'd1 << CAM_SH) + 64'(SCREEN_COLUMNS)
                                               - 64'd1) / 64'(SCREEN_COLUMNS));

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CAMG = 5'd1;
    localparam logic [4:0] S_CAMW = 5'd2;
    localparam logic [4:0] S_MULX = 5'd3;
    localparam logic [4:0] S_MULY = 5'd4;
    localparam logic [4:0] S_RAYY = 5'd5;
    localparam logic [4:0] S_DXG  = 5'd6;
    localparam logic [4:0] S_DXW  = 5'd7;
    localparam logic [4:0] S_DYG  = 5'd8;
    localparam logic [4:0] S_DYW  = 5'd9;
    localparam logic [4:0] S_SXM  = 5'd10;
    localparam logic [4:0] S_SYM  = 5'd11;
    localparam logic [4:0] S_SYS  = 5'd12;
    localparam logic [4:0] S_STEP = 5'd13;
    localparam logic [4:0] S_TEST = 5'd14;
    localparam logic [4:0] S_LHG  = 5'd15;
    localparam logic [4:0] S_LHW  = 5'd16;
    localparam logic [4:0] S_TEXM = 5'd17;
    localparam logic [4:0] S_FIN  = 5'd18;
    localparam logic [4:0] S_MISS = 5'd19;

    logic [4:0]               state_reg;
    logic [20:0]              pos_x_reg, pos_y_reg;
    logic [18:0]              dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [9:0]               col_reg;
    logic signed [CAM_W-1:0]  cam_reg;
    logic signed [RAY_W-1:0]  rx_reg, ry_reg;
    logic [31:0]              dx_reg, dy_reg;
    logic [DIST_W-1:0]        sx_reg, sy_reg, perp_reg;
    logic signed [CW-1:0]     mx_reg, my_reg;
    logic                     side_reg;
    logic [SW-1:0]            steps_reg;
    logic [7:0]               cell_reg;
    logic [15:0]              lh_reg;
    logic signed [65:0]       mul_p_reg;
    drgc_pkg::result_t        res_reg;
    logic                     done_reg;

    logic signed [32:0]       mul_a, mul_b;
    drgc_pkg::div_req_t       div_req;
    drgc_pkg::div_rsp_t       div_rsp;
    logic                     accept;
    logic                     ram_we;
    logic [AW-1:0]            raddr;
    logic [7:0]               rdata;
    logic                     cam_neg;
    logic [12:0]              cam_mag;
    logic [28:0]              cam_num;
    logic                     rx_neg, ry_neg;
    logic [RAY_W-1:0]         rx_abs, ry_abs;
    logic [31:0]              recip_sat;
    logic [16:0]              fx_sel, fy_sel;
    logic                     step_x;
    logic [DIST_W-1:0]        sx_next, sy_next;
    logic signed [CW-1:0]     mx_next, my_next;
    logic                     in_map;
    logic [31:0]              u_low;
    logic [31:0]              tex_prod;
    logic [15:0]              tex_raw, tex_col;
    logic                     mirror;
    logic [14:0]              half_lh;
    logic [16:0]              ds_val, de_sum, de_val;
    logic [7:0]               tex_idx;
    drgc_pkg::result_t        miss_res;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = state_reg != S_IDLE;
    assign ram_we = accept && (cmd.operation == drgc_pkg::OP_WRITE)
                    && ({7'd0, cmd.cell_index} < 17'(CELLS));

    drgc_ram #(
        .WIDTH(8),
        .DEPTH(CELLS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(cmd.cell_index)),
        .wdata(cmd.cell_value),
        .raddr(raddr),
        .rdata(rdata)
    );

    drgc_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    always_comb
    begin
        cam_neg   = {2'b00, col_reg, 1'b0} < COLS_L;
        cam_mag   = cam_neg ? COLS_L - {2'b00, col_reg, 1'b0}
                            : {2'b00, col_reg, 1'b0} - COLS_L;
        cam_num   = {cam_mag, 16'h0000} + (cam_neg ? 29'(SCREEN_COLUMNS - 1) : 29'd0);
        rx_neg    = rx_reg < 0;
        ry_neg    = ry_reg < 0;
        rx_abs    = rx_neg ? RAY_W'(-rx_reg) : RAY_W'(rx_reg);
        ry_abs    = ry_neg ? RAY_W'(-ry_reg) : RAY_W'(ry_reg);
        recip_sat = div_rsp.quotient[NW-1] ? 32'hFFFF_FFFF : div_rsp.quotient[31:0];
        fx_sel    = rx_neg ? {1'b0, pos_x_reg[15:0]} : 17'h10000 - {1'b0, pos_x_reg[15:0]};
        fy_sel    = ry_neg ? {1'b0, pos_y_reg[15:0]} : 17'h10000 - {1'b0, pos_y_reg[15:0]};

        div_req.go    = 1'b0;
        div_req.numer = RECIP_NUM;
        div_req.denom = DW'(rx_abs);
        case (state_reg)
            S_DXG:
            begin
                div_req.go = 1'b1;
            end
            S_DYG:
            begin
                div_req.go    = 1'b1;
                div_req.denom = DW'(ry_abs);
            end
            S_LHG:
            begin
                div_req.go    = perp_reg != '0;
                div_req.numer = LH_NUMER;
                div_req.denom = DW'({perp_reg, 1'b0});
            end
            default:
            begin
            end
        endcase

        mul_a = 33'(signed'(plane_x_reg));
        mul_b = 33'(cam_reg);
        case (state_reg)
            S_CAMG:
            begin
                mul_a = signed'({4'b0000, cam_num});
                mul_b = signed'(CAM_MUL);
            end
            S_MULY:
            begin
                mul_a = 33'(signed'(plane_y_reg));
            end
            S_SXM:
            begin
                mul_a = signed'({16'h0000, fx_sel});
                mul_b = signed'({1'b0, dx_reg});
            end
            S_SYM:
            begin
                mul_a = signed'({16'h0000, fy_sel});
                mul_b = signed'({1'b0, dy_reg});
            end
            S_TEXM:
            begin
                mul_a = signed'({1'b0, perp_reg[31:0]});
                mul_b = side_reg ? 33'(rx_reg) : 33'(ry_reg);
            end
            default:
            begin
            end
        endcase

        step_x  = sx_reg < sy_reg;
        sx_next = step_x ? sx_reg + DIST_W'(dx_reg) : sx_reg;
        sy_next = step_x ? sy_reg : sy_reg + DIST_W'(dy_reg);
        mx_next = step_x ? (rx_neg ? mx_reg - ONE_S : mx_reg + ONE_S) : mx_reg;
        my_next = step_x ? my_reg : (ry_neg ? my_reg - ONE_S : my_reg + ONE_S);
        in_map  = (mx_next >= 0) && (mx_next < SIDE_S) && (my_next >= 0) && (my_next < SIDE_S);
        raddr   = AW'(my_next) * AW'(MAP_SIDE) + AW'(mx_next);

        u_low    = (side_reg ? {pos_x_reg[15:0], 16'h0000} : {pos_y_reg[15:0], 16'h0000})
                   + mul_p_reg[31:0];
        tex_prod = {16'h0000, u_low[31:16]} * {15'd0, TEX_SIDE_L};
        tex_raw  = tex_prod[31:16];
        mirror   = (!side_reg && !rx_neg && (rx_reg != 0)) || (side_reg && ry_neg);
        tex_col  = mirror ? 16'(TEX_SIDE_L) - tex_raw - 16'd1 : tex_raw;
        half_lh  = lh_reg[15:1];
        ds_val   = ({2'b00, half_lh} >= HALF_ROWS_L) ? '0 : HALF_ROWS_L - {2'b00, half_lh};
        de_sum   = {2'b00, half_lh} + HALF_ROWS_L;
        de_val   = (de_sum >= ROWS_L) ? ROWS_L - 17'd1 : de_sum;
        tex_idx  = cell_reg - 8'd1;

        miss_res            = '0;
        miss_res.out_column = col_reg;
        miss_res.no_hit     = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            pos_x_reg   <= drgc_pkg::POS_X_RST;
            pos_y_reg   <= drgc_pkg::POS_Y_RST;
            dir_x_reg   <= drgc_pkg::DIR_X_RST;
            dir_y_reg   <= drgc_pkg::DIR_Y_RST;
            plane_x_reg <= drgc_pkg::PLANE_X_RST;
            plane_y_reg <= drgc_pkg::PLANE_Y_RST;
            steps_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    drgc_pkg::REG_POS_X:   pos_x_reg   <= cfg_data;
                    drgc_pkg::REG_POS_Y:   pos_y_reg   <= cfg_data;
                    drgc_pkg::REG_DIR_X:   dir_x_reg   <= cfg_data[18:0];
                    drgc_pkg::REG_DIR_Y:   dir_y_reg   <= cfg_data[18:0];
                    drgc_pkg::REG_PLANE_X: plane_x_reg <= cfg_data[18:0];
                    drgc_pkg::REG_PLANE_Y: plane_y_reg <= cfg_data[18:0];
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (cmd.operation == drgc_pkg::OP_CAST))
                    begin
                        col_reg   <= cmd.column;
                        state_reg <= S_CAMG;
                    end
                end
                S_CAMG:
                begin
                    state_reg <= S_CAMW;
                end
                S_CAMW:
                begin
                    cam_reg   <= cam_neg ? -CAM_W'(mul_p_reg >>> CAM_SH)
                                         : CAM_W'(mul_p_reg >>> CAM_SH);
                    state_reg <= S_MULX;
                end
                S_MULX:
                begin
                    state_reg <= S_MULY;
                end
                S_MULY:
                begin
                    rx_reg    <= RAY_W'(signed'(dir_x_reg)) + RAY_W'(mul_p_reg >>> 16);
                    state_reg <= S_RAYY;
                end
                S_RAYY:
                begin
                    ry_reg    <= RAY_W'(signed'(dir_y_reg)) + RAY_W'(mul_p_reg >>> 16);
                    state_reg <= S_DXG;
                end
                S_DXG:
                begin
                    state_reg <= S_DXW;
                end
                S_DXW:
                begin
                    if (div_rsp.done)
                    begin
                        dx_reg    <= recip_sat;
                        state_reg <= S_DYG;
                    end
                end
                S_DYG:
                begin
                    state_reg <= S_DYW;
                end
                S_DYW:
                begin
                    if (div_rsp.done)
                    begin
                        dy_reg    <= recip_sat;
                        state_reg <= S_SXM;
                    end
                end
                S_SXM:
                begin
                    state_reg <= S_SYM;
                end
                S_SYM:
                begin
                    sx_reg    <= mul_p_reg[16 +: DIST_W];
                    state_reg <= S_SYS;
                end
                S_SYS:
                begin
                    sy_reg    <= mul_p_reg[16 +: DIST_W];
                    mx_reg    <= signed'(CW'(pos_x_reg[20:16]));
                    my_reg    <= signed'(CW'(pos_y_reg[20:16]));
                    steps_reg <= '0;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    sx_reg    <= sx_next;
                    sy_reg    <= sy_next;
                    mx_reg    <= mx_next;
                    my_reg    <= my_next;
                    side_reg  <= !step_x;
                    state_reg <= in_map ? S_TEST : S_MISS;
                end
                S_TEST:
                begin
                    if (rdata != 8'd0)
                    begin
                        cell_reg  <= rdata;
                        perp_reg  <= side_reg ? sy_reg - DIST_W'(dy_reg)
                                              : sx_reg - DIST_W'(dx_reg);
                        state_reg <= S_LHG;
                    end
                    else if (steps_reg == SW'(STEP_LIMIT - 1))
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_STEP;
                    end
                end
                S_LHG:
                begin
                    if (perp_reg == '0)
                    begin
                        lh_reg    <= 16'hFFFF;
                        state_reg <= S_TEXM;
                    end
                    else
                    begin
                        state_reg <= S_LHW;
                    end
                end
                S_LHW:
                begin
                    if (div_rsp.done)
                    begin
                        lh_reg    <= (|div_rsp.quotient[NW-1:16]) ? 16'hFFFF
                                                                  : div_rsp.quotient[15:0];
                        state_reg <= S_TEXM;
                    end
                end
                S_TEXM:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    res_reg.out_column     <= col_reg;
                    res_reg.side_hit       <= side_reg;
                    res_reg.hit_cell_x     <= mx_reg[4:0];
                    res_reg.hit_cell_y     <= my_reg[4:0];
                    res_reg.wall_distance  <= (|perp_reg[DIST_W-1:32]) ? 32'hFFFF_FFFF
                                                                       : perp_reg[31:0];
                    res_reg.line_height    <= lh_reg;
                    res_reg.draw_start     <= ds_val[8:0];
                    res_reg.draw_end       <= de_val[8:0];
                    res_reg.texture_index  <= ({1'b0, tex_idx} < TEX_CNT_L) ? tex_idx[2:0] : 3'd0;
                    res_reg.texture_column <= tex_col[5:0];
                    res_reg.no_hit         <= 1'b0;
                    done_reg               <= 1'b1;
                    state_reg              <= S_IDLE;
                end
                S_MISS:
                begin
                    res_reg   <= miss_res;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[sv/drgc_checker.sv]
// Port-level checker for the raycaster column unit, bound to the top level.
module drgc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input drgc_pkg::cmd_t    cmd,
    input logic              done,
    input drgc_pkg::result_t result,
    input logic              cfg_write,
    input logic [2:0]        cfg_index,
    input logic [20:0]       cfg_data
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.operation == drgc_pkg::OP_WRITE)) |=> !busy && !done)
        else $error("map write made the unit busy");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.operation == drgc_pkg::OP_CAST)) |=> busy)
        else $error("cast did not start");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.no_hit) |-> (result.wall_distance == 32'd0)
            && (result.line_height == 16'd0) && (result.texture_column == 6'd0))
        else $error("no-hit result carries data");

endmodule

bind dda_grid_raycast_column_unit drgc_checker u_drgc_checker (.*);
